FILE: sv/hsw_pkg.sv
package hsw_pkg;

	// register map
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPACING = 2'd1;

	localparam int PC_W = 13;
	localparam int SPACING_W = 16;
	localparam logic [PC_W-1:0] POINT_COUNT_RST = 13'd7;
	localparam logic [SPACING_W-1:0] SPACING_RST = 16'd256;

	// output field widths
	localparam int POS_W = 24;
	localparam int AX_W = 7;
	localparam int IDX_OUT_W = 12;

	localparam int OUT_MAX = 8388607;
	localparam int OUT_MIN = -8388608;

	// sqrt(3)/2 in Q0.16
	localparam logic [15:0] HALF_SQRT3_Q16 = 16'd56756;

	localparam logic [2:0] SIDE_LAST = 3'd5;

	// axial step along each side of a ring
	function automatic logic signed [1:0] dir_q(input logic [2:0] side);
		logic signed [1:0] d;
		case (side)
			3'd0: d = 2'sd1;
			3'd1: d = 2'sd1;
			3'd2: d = 2'sd0;
			3'd3: d = -2'sd1;
			3'd4: d = -2'sd1;
			default: d = 2'sd0;
		endcase
		return d;
	endfunction

	function automatic logic signed [1:0] dir_r(input logic [2:0] side);
		logic signed [1:0] d;
		case (side)
			3'd0: d = 2'sd0;
			3'd1: d = -2'sd1;
			3'd2: d = -2'sd1;
			3'd3: d = 2'sd0;
			3'd4: d = 2'sd1;
			default: d = 2'sd1;
		endcase
		return d;
	endfunction

endpackage

FILE: sv/hsw_queue.sv
module hsw_queue import hsw_pkg::*; #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	input  logic              pop,
	output logic [DATA_W-1:0] pop_data,
	output logic              full,
	output logic              empty
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + CNT_W'(1);
				2'b01: cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: sv/hsw_front.sv
module hsw_front import hsw_pkg::*; #(
	parameter int MAX_POINTS = 4096,
	parameter int COORD_BITS = 7,
	localparam int IDX_W = $clog2(MAX_POINTS),
	localparam int DATA_W = 2 * COORD_BITS + IDX_W + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              restart,
	input  logic              full,
	input  logic [PC_W-1:0]   point_count,
	output logic              push,
	output logic [DATA_W-1:0] push_data
);

	localparam int RING_W = $clog2(MAX_POINTS) / 2 + 1;
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int CMP_W = (CNT_W > PC_W) ? CNT_W : PC_W;
	localparam int CW = COORD_BITS;

	logic [RING_W-1:0] ring_q, ring_n, cur_ring, step_q, step_n, cur_step, step_inc;
	logic [2:0] side_q, side_n, cur_side;
	logic [CW-1:0] wq_q, wq_n, cur_wq, wr_q, wr_n, cur_wr;
	logic [IDX_W-1:0] cnt_q, cnt_n, cur_cnt;
	logic [CMP_W-1:0] pc_ext, count_eff;
	logic [15:0] start_k;
	logic signed [1:0] dq, dr;
	logic cur_last;
	logic acc;

	assign acc = in_valid && !full;
	assign push = acc;

	// saturate the configured count into 1..MAX_POINTS
	always_comb begin
		pc_ext = CMP_W'(point_count);
		if (pc_ext == '0) begin
			count_eff = CMP_W'(1);
		end else if (pc_ext > CMP_W'(MAX_POINTS)) begin
			count_eff = CMP_W'(MAX_POINTS);
		end else begin
			count_eff = pc_ext;
		end
	end

	always_comb begin
		cur_ring = restart ? '0 : ring_q;
		cur_side = restart ? '0 : side_q;
		cur_step = restart ? '0 : step_q;
		cur_wq = restart ? '0 : wq_q;
		cur_wr = restart ? '0 : wr_q;
		cur_cnt = restart ? '0 : cnt_q;
		cur_last = (CMP_W'(cur_cnt) + CMP_W'(1)) >= count_eff;
		push_data = {cur_wq, cur_wr, cur_cnt, cur_last};

		dq = dir_q(cur_side);
		dr = dir_r(cur_side);
		start_k = 16'(cur_ring) + 16'd1;
		step_inc = cur_step + RING_W'(1);

		ring_n = cur_ring;
		side_n = cur_side;
		step_n = cur_step;
		wq_n = cur_wq;
		wr_n = cur_wr;
		cnt_n = cur_cnt + IDX_W'(1);

		if (cur_last) begin
			ring_n = '0;
			side_n = '0;
			step_n = '0;
			wq_n = '0;
			wr_n = '0;
			cnt_n = '0;
		end else if (cur_ring == '0) begin
			ring_n = RING_W'(start_k);
			side_n = '0;
			step_n = '0;
			wq_n = CW'(16'd0 - start_k);
			wr_n = CW'(start_k);
		end else begin
			wq_n = cur_wq + {{(CW-2){dq[1]}}, dq};
			wr_n = cur_wr + {{(CW-2){dr[1]}}, dr};
			step_n = step_inc;
			if (step_inc >= cur_ring) begin
				step_n = '0;
				side_n = cur_side + 3'd1;
				if (cur_side == SIDE_LAST) begin
					// ring done, jump to the start corner of the next one
					ring_n = RING_W'(start_k);
					side_n = '0;
					wq_n = CW'(16'd0 - start_k);
					wr_n = CW'(start_k);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q <= '0;
			side_q <= '0;
			step_q <= '0;
			wq_q <= '0;
			wr_q <= '0;
			cnt_q <= '0;
		end else if (acc) begin
			ring_q <= ring_n;
			side_q <= side_n;
			step_q <= step_n;
			wq_q <= wq_n;
			wr_q <= wr_n;
			cnt_q <= cnt_n;
		end
	end

	a_center_state: assert property (@(posedge clk) disable iff (!arst_n)
		ring_q == '0 |-> (wq_q == '0 && wr_q == '0 && side_q == '0 && step_q == '0))
		else $error("center pending with nonzero walk state");

	a_ring_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		ring_q != '0 |-> (step_q < ring_q && side_q <= SIDE_LAST))
		else $error("walk position outside its ring");

	a_wrap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		acc && cur_last |=> (cnt_q == '0 && ring_q == '0))
		else $error("walk did not wrap after last word");

endmodule

FILE: sv/hsw_back.sv
module hsw_back import hsw_pkg::*; #(
	parameter int MAX_POINTS = 4096,
	parameter int COORD_BITS = 7,
	localparam int IDX_W = $clog2(MAX_POINTS),
	localparam int DATA_W = 2 * COORD_BITS + IDX_W + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  empty,
	input  logic [DATA_W-1:0]     pop_data,
	output logic                  pop,
	input  logic [SPACING_W-1:0]  spacing,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [POS_W-1:0]      pos_x,
	output logic [POS_W-1:0]      pos_y,
	output logic [AX_W-1:0]       axial_q,
	output logic [AX_W-1:0]       axial_r,
	output logic [IDX_OUT_W-1:0]  point_index,
	output logic                  last
);

	localparam int CW = COORD_BITS;
	localparam int SW = CW + 2;
	localparam int PXW = SW + 17;
	localparam int PY0W = CW + 17;
	localparam int PYW = PY0W + 17;
	localparam int RW = PYW + 1;
	localparam logic signed [RW-1:0] SAT_HI = RW'(OUT_MAX);
	localparam logic signed [RW-1:0] SAT_LO = RW'(OUT_MIN);

	logic en;
	logic v_s1, v_s2, v_s3, out_valid_q;

	logic signed [CW-1:0] hq, hr;
	logic [IDX_W-1:0] hidx;
	logic hlast;

	logic signed [CW-1:0] q_s1, r_s1, q_s2, r_s2, q_s3, r_s3;
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3;
	logic last_s1, last_s2, last_s3;
	logic signed [SW-1:0] sum_s1;
	logic signed [PXW-1:0] px_s2, px_s3;
	logic signed [PY0W-1:0] py0_s2;
	logic signed [PYW-1:0] py_s3;

	logic signed [SW-1:0] qe, re;
	logic signed [RW-1:0] xw, yw, xadj, yadj, xsum, ysum, xr, yr;

	logic [POS_W-1:0] pos_x_q, pos_y_q;
	logic [AX_W-1:0] axial_q_q, axial_r_q;
	logic [IDX_OUT_W-1:0] point_index_q;
	logic last_q;

	function automatic logic [POS_W-1:0] sat_pos(input logic signed [RW-1:0] v);
		logic signed [RW-1:0] s;
		s = v;
		if (v > SAT_HI) begin
			s = SAT_HI;
		end else if (v < SAT_LO) begin
			s = SAT_LO;
		end
		return s[POS_W-1:0];
	endfunction

	assign en = !out_valid_q || out_ready;
	assign pop = en && !empty;

	assign {hq, hr, hidx, hlast} = pop_data;
	assign qe = SW'(hq);
	assign re = SW'(hr);

	// round half away from zero: bias one less on negative values, then floor
	always_comb begin
		xw = RW'(px_s3);
		yw = RW'(py_s3);
		xadj = xw[RW-1] ? RW'(0) : RW'(1);
		yadj = yw[RW-1] ? RW'(32767) : RW'(32768);
		xsum = xw + xadj;
		ysum = yw + yadj;
		xr = xsum >>> 1;
		yr = ysum >>> 16;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1 <= hq;
			r_s1 <= hr;
			idx_s1 <= hidx;
			last_s1 <= hlast;
			sum_s1 <= (qe <<< 1) + re;

			q_s2 <= q_s1;
			r_s2 <= r_s1;
			idx_s2 <= idx_s1;
			last_s2 <= last_s1;
			px_s2 <= $signed({1'b0, spacing}) * sum_s1;
			py0_s2 <= $signed({1'b0, spacing}) * r_s1;

			q_s3 <= q_s2;
			r_s3 <= r_s2;
			idx_s3 <= idx_s2;
			last_s3 <= last_s2;
			px_s3 <= px_s2;
			py_s3 <= py0_s2 * $signed({1'b0, HALF_SQRT3_Q16});

			pos_x_q <= sat_pos(xr);
			pos_y_q <= sat_pos(yr);
			axial_q_q <= AX_W'(q_s3);
			axial_r_q <= AX_W'(r_s3);
			point_index_q <= IDX_OUT_W'(idx_s3);
			last_q <= last_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x = pos_x_q;
	assign pos_y = pos_y_q;
	assign axial_q = axial_q_q;
	assign axial_r = axial_r_q;
	assign point_index = point_index_q;
	assign last = last_q;

endmodule

FILE: sv/hex_spiral_point_walker_unit.sv
// Hexagonal spiral walker: each accepted request word returns one point of the spiral (center,
// then ring k from axial (-k,k) around six sides of k steps), with its axial coordinates, index,
// last flag and Q15.8 position scaled by spacing. A walker front end takes one word per cycle
// while the two-entry queue it feeds is not full; the back end runs a sum stage, two multiply
// stages and an output register that rounds and saturates, so one word per cycle is sustained
// while out_ready stays high. A word passes from the queue through the sum, multiply and output
// registers in order. Registers: 0 point_count (0 acts as 1, saturates at MAX_POINTS),
// 1 spacing; write them only while no request is in flight.
module hex_spiral_point_walker_unit import hsw_pkg::*; #(
	parameter int MAX_POINTS = 4096,
	parameter int COORD_BITS = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  restart,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [POS_W-1:0]      pos_x,
	output logic [POS_W-1:0]      pos_y,
	output logic [AX_W-1:0]       axial_q,
	output logic [AX_W-1:0]       axial_r,
	output logic [IDX_OUT_W-1:0]  point_index,
	output logic                  last,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int DATA_W = 2 * COORD_BITS + IDX_W + 1;

	logic [PC_W-1:0] point_count_q;
	logic [SPACING_W-1:0] spacing_q;

	logic push, pop, full, empty;
	logic [DATA_W-1:0] push_data, pop_data;

	assign cfg_ready = 1'b1;
	assign in_ready = !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= POINT_COUNT_RST;
			spacing_q <= SPACING_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_POINT_COUNT: point_count_q <= cfg_data[PC_W-1:0];
				REG_SPACING: spacing_q <= cfg_data[SPACING_W-1:0];
				default: ;
			endcase
		end
	end

	hsw_front #(
		.MAX_POINTS(MAX_POINTS),
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.restart    (restart),
		.full       (full),
		.point_count(point_count_q),
		.push       (push),
		.push_data  (push_data)
	);

	hsw_queue #(
		.DATA_W(DATA_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.full     (full),
		.empty    (empty)
	);

	hsw_back #(
		.MAX_POINTS(MAX_POINTS),
		.COORD_BITS(COORD_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (empty),
		.pop_data   (pop_data),
		.pop        (pop),
		.spacing    (spacing_q),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.axial_q    (axial_q),
		.axial_r    (axial_r),
		.point_index(point_index),
		.last       (last)
	);

endmodule

FILE: dv/testbench.sv
module testbench;
	import hsw_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_POINTS = 4096;
	localparam longint HALF_SQRT3 = 56756;
	localparam int RANDOM_WORDS = 1950;
	localparam int SETTLE_CYCLES = 20;
	localparam int STALL_LIMIT = 2000;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_B = 2'd3;
	localparam logic signed [1:0] STEP_Q [6] = '{2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1, 2'sd0};
	localparam logic signed [1:0] STEP_R [6] = '{2'sd0, -2'sd1, -2'sd1, 2'sd0, 2'sd1, 2'sd1};

	typedef struct {
		logic [POS_W-1:0]     x;
		logic [POS_W-1:0]     y;
		logic [AX_W-1:0]      q;
		logic [AX_W-1:0]      r;
		logic [IDX_OUT_W-1:0] idx;
		logic                 last;
	} spiral_point_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic                  restart;
	logic                  out_valid;
	logic                  out_ready;
	logic [POS_W-1:0]      pos_x;
	logic [POS_W-1:0]      pos_y;
	logic [AX_W-1:0]       axial_q;
	logic [AX_W-1:0]       axial_r;
	logic [IDX_OUT_W-1:0]  point_index;
	logic                  last;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	hex_spiral_point_walker_unit dut (.*);

	// predictor copy of the registers and the walk
	logic [PC_W-1:0]        pc_cfg;
	logic [SPACING_W-1:0]   spacing_cfg;
	logic [6:0]             ring_no;
	logic [2:0]             side_no;
	logic [6:0]             step_no;
	logic signed [AX_W-1:0] walk_q;
	logic signed [AX_W-1:0] walk_r;
	logic [IDX_OUT_W-1:0]   emitted;

	spiral_point_t expected_points[$];
	int errors = 0;
	int sent_words = 0;
	int random_words = 0;
	int checked_points = 0;
	int closed_spirals = 0;
	int highest_index = 0;
	int settings_used = 1;
	int idle_cycles = 0;
	bit steady_flow = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void walk_home();
		ring_no = '0;
		side_no = '0;
		step_no = '0;
		walk_q = '0;
		walk_r = '0;
		emitted = '0;
	endfunction

	function automatic void start_ring(input logic [6:0] k);
		ring_no = k;
		side_no = '0;
		step_no = '0;
		walk_q = -k;
		walk_r = k;
	endfunction

	// divide by 2^sh, nearest with ties away from zero, clamp to Q15.8
	function automatic logic [POS_W-1:0] round_q8(input longint num, input int sh);
		longint mag;
		longint quo;
		mag = (num < 0) ? -num : num;
		quo = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
		if (num < 0)
			quo = -quo;
		if (quo > OUT_MAX)
			quo = OUT_MAX;
		if (quo < OUT_MIN)
			quo = OUT_MIN;
		return quo[POS_W-1:0];
	endfunction

	function automatic spiral_point_t next_spiral_point(input logic rst_bit);
		spiral_point_t pt;
		int span;
		int qi;
		int ri;
		span = (pc_cfg == 0) ? 1 : ((pc_cfg > MAX_POINTS) ? MAX_POINTS : int'(pc_cfg));
		if (rst_bit)
			walk_home();
		qi = walk_q;
		ri = walk_r;
		pt.q = walk_q;
		pt.r = walk_r;
		pt.idx = emitted;
		pt.last = (int'(emitted) + 1 >= span);
		pt.x = round_q8(longint'(spacing_cfg) * (2 * qi + ri), 1);
		pt.y = round_q8(longint'(spacing_cfg) * ri * HALF_SQRT3, 16);
		if (pt.last) begin
			walk_home();
		end else begin
			emitted = emitted + 1'b1;
			if (ring_no == 0) begin
				start_ring(7'd1);
			end else begin
				walk_q = walk_q + STEP_Q[side_no];
				walk_r = walk_r + STEP_R[side_no];
				step_no = step_no + 1'b1;
				if (step_no >= ring_no) begin
					step_no = '0;
					side_no = side_no + 1'b1;
					if (side_no >= 6)
						start_ring(ring_no + 1'b1);
				end
			end
		end
		return pt;
	endfunction

	// mostly back to back, sometimes a short gap, rarely a long pause
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 48);
	endfunction

	task automatic send_request(input logic rst_bit);
		int gap;
		in_valid <= 1'b1;
		restart <= rst_bit;
		do @(posedge clk); while (!in_ready);
		expected_points.push_back(next_spiral_point(rst_bit));
		sent_words++;
		gap = steady_flow ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_POINT_COUNT: pc_cfg = data[PC_W-1:0];
			REG_SPACING: spacing_cfg = data;
			default: ;
		endcase
	endtask

	task automatic program_regs(input logic [CFG_DATA_W-1:0] count_word,
			input logic [CFG_DATA_W-1:0] spacing_word);
		drain_results();
		set_reg(REG_POINT_COUNT, count_word);
		set_reg(REG_SPACING, spacing_word);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// reset values: seven points, unit spacing, wraps after the first ring
	task automatic test_reset_defaults();
		repeat (9) send_request(1'b0);
	endtask

	task automatic test_count_corners();
		// zero count acts as one: every point is the center and last
		program_regs(16'h0000, 16'd256);
		send_request(1'b0);
		send_request(1'b1);
		send_request(1'b0);
		// count beyond the maximum saturates, widest spacing, restart on center and mid ring
		program_regs(16'hFFFF, 16'hFFFF);
		send_request(1'b1);
		send_request(1'b0);
		send_request(1'b0);
		send_request(1'b0);
		send_request(1'b1);
		send_request(1'b0);
		// upper data bits above the count width are dropped, zero spacing
		program_regs(16'hE001, 16'h0000);
		send_request(1'b0);
		send_request(1'b0);
	endtask

	task automatic test_unmapped_index();
		drain_results();
		set_reg(REG_UNMAPPED_A, 16'($urandom));
		set_reg(REG_UNMAPPED_B, 16'($urandom));
		cfg_valid <= 1'b0;
		repeat (3) send_request(1'b0);
	endtask

	task automatic test_random_spirals();
		int phase;
		int words;
		int noise;
		int pause_at;
		logic [PC_W-1:0] span;
		logic [SPACING_W-1:0] pitch;
		phase = 0;
		while (random_words < RANDOM_WORDS) begin
			case (phase)
				0: begin
					span = 13'd4096;
					pitch = 16'hFFFF;
					words = 300;
					noise = 0;
				end
				1: begin
					span = 13'h1FFF;
					pitch = 16'h0000;
					words = 40;
					noise = 0;
				end
				2: begin
					// one long spiral walked to its end and past the wrap
					span = 13'($urandom_range(300, 700));
					pitch = 16'($urandom);
					words = int'(span) + 20;
					noise = 0;
				end
				default: begin
					span = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(1, 8))
						: 13'($urandom_range(1, 80));
					case ($urandom_range(0, 5))
						0: pitch = 16'h0000;
						1: pitch = 16'hFFFF;
						default: pitch = 16'($urandom);
					endcase
					words = $urandom_range(60, 120);
					noise = ($urandom_range(0, 2) == 0) ? 6 : 0;
				end
			endcase
			steady_flow = (phase == 0) || ($urandom_range(0, 3) == 0);
			program_regs({3'($urandom), span}, pitch);
			pause_at = (phase % 2 == 1) ? words / 2 : -1;
			for (int i = 0; i < words; i++) begin
				if (i == pause_at)
					drain_results();
				send_request(noise != 0 && $urandom_range(1, noise) == 1);
				random_words++;
			end
			phase++;
		end
		steady_flow = 0;
	endtask

	// result side backpressure
	initial begin
		int hold;
		logic level;
		hold = 0;
		level = 1'b1;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (steady_flow) begin
				out_ready <= 1'b1;
			end else begin
				if (hold == 0) begin
					level = ~level;
					hold = level ? $urandom_range(1, 12) : 1 + pick_gap();
				end
				hold--;
				out_ready <= level;
			end
		end
	end

	function automatic void compare_field(input string field, input longint want, input longint got);
		if (want != got) begin
			$display("%0t ns: result %0d %s mismatch, expected %0d, actual %0d",
				$time, checked_points, field, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin : check_points
		spiral_point_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_points.size() == 0) begin
				$display("%0t ns: unexpected word, expected none, actual x %0d y %0d index %0d",
					$time, $signed(pos_x), $signed(pos_y), point_index);
				errors++;
			end else begin
				want = expected_points.pop_front();
				compare_field("pos_x", $signed(want.x), $signed(pos_x));
				compare_field("pos_y", $signed(want.y), $signed(pos_y));
				compare_field("axial_q", $signed(want.q), $signed(axial_q));
				compare_field("axial_r", $signed(want.r), $signed(axial_r));
				compare_field("point_index", want.idx, point_index);
				compare_field("last", want.last, last);
				if (want.last)
					closed_spirals++;
				if (int'(want.idx) > highest_index)
					highest_index = want.idx;
			end
			checked_points++;
		end
	end

	// watchdog on cycles where no word moves on any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t ns: no progress for %0d cycles", $time, idle_cycles);
			$display("testbench NOT OK");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		restart <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_POINT_COUNT;
		cfg_data <= '0;
		pc_cfg = 13'd7;
		spacing_cfg = 16'd256;
		walk_home();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_count_corners();
		test_unmapped_index();
		test_random_spirals();
		drain_results();
		errors += expected_points.size();

		$display("%0d request words (%0d random) over %0d register settings, %0d results checked",
			sent_words, random_words, settings_used, checked_points);
		$display("%0d spirals closed by last, highest point index %0d",
			closed_spirals, highest_index);
		if (errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
